/* src/assert_macros.svh */
// Assertion macros used by the top level of the great-circle distance block.
// Stand-alone header with no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/gcd_pkg.sv */
// Shared widths, constants, cell payload types and CORDIC table functions
// for the great-circle distance block. No dependencies.
package gcd_pkg;

  localparam int FRAC     = 30;          // fraction bits of angles and ratios
  localparam int STEPS    = 32;          // CORDIC micro-rotations
  localparam int XW       = FRAC + 3;    // CORDIC datapath width
  localparam int UW       = 17;          // angles in half-minute units
  localparam int RW       = 14;          // folded angle magnitude
  localparam int RADW     = 2 * FRAC + 2;
  localparam int REMW     = FRAC + 4;
  localparam int RADIUS_W = 13;
  localparam int DIST_W   = 15;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6371;
  localparam logic signed [UW-1:0] MIN_PER_DEG  = 17'sd60;
  localparam logic signed [UW-1:0] QUARTER_TURN = 17'sd10800;
  localparam logic signed [UW-1:0] HALF_TURN    = 17'sd21600;
  localparam logic signed [UW-1:0] FULL_TURN    = 17'sd43200;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452305;
  localparam logic [63:0] STEP_Q62 = (PI_Q60 * 64'd4) / 64'd21600;

  // Rounds a Q62 value half up to FRAC fraction bits.
  function automatic logic [63:0] q62_to_qf(input logic [63:0] v);
    return (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  endfunction

  // Restoring long division, used only to build constants.
  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from its power series in Q62, rounded to FRAC bits.
  function automatic logic signed [XW-1:0] atan_qf(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = long_div(64'd1 << (62 - e), 64'(2 * k + 1));
          sum  = k[0] ? sum - term : sum + term;
        end
      end
    end
    return XW'(q62_to_qf(sum));
  endfunction

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(q62_to_qf(GAIN_Q62));

  typedef struct packed {
    logic                 vld;
    logic                 neg;   // negate x at the end of the chain
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic            vld;
    logic [REMW-1:0] rem;
    logic [FRAC:0]   root;
    logic [RADW-1:0] rad;
  } sqrt_t;

endpackage

/* src/gcd_cordic_cell.sv */
// One CORDIC micro-rotation with its output register.
// Depends on gcd_pkg for the payload type and the arctangent table.
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  localparam logic signed [XW-1:0] ANGLE = atan_qf(STAGE);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 ccw;
  cordic_t              nxt;

  always_comb begin
    xs  = din.x >>> STAGE;
    ys  = din.y >>> STAGE;
    // Vectoring drives y to zero; rotation drives z to zero.
    ccw = VECTOR ? din.y[XW-1] : ~din.z[XW-1];
    nxt = din;
    if (ccw) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ANGLE;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.neg <= nxt.neg;
      dout.x   <= nxt.x;
      dout.y   <= nxt.y;
      dout.z   <= nxt.z;
    end
  end

endmodule

/* src/gcd_sqrt_cell.sv */
// One digit of a restoring square root: two radicand bits in, one root bit out.
// Depends on gcd_pkg for the payload type.
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  sqrt_t           nxt;

  always_comb begin
    rem_sh  = {din.rem[REMW-3:0], din.rad[RADW-1 -: 2]};
    trial   = REMW'({din.root, 2'b01});
    nxt     = din;
    nxt.rad = {din.rad[RADW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {din.root[FRAC-1:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {din.root[FRAC-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= nxt.rem;
      dout.root <= nxt.root;
      dout.rad  <= nxt.rad;
    end
  end

endmodule

/* src/great_circle_distance.sv */
// Top level of the haversine great-circle distance block.
// Depends on gcd_pkg, gcd_cordic_cell, gcd_sqrt_cell and assert_macros.svh.
//
// Usage:
// A beat on the slave stream carries two positions, each as signed whole
// degrees plus minutes for latitude and longitude. A beat on the master
// stream carries the distance in whole kilometres, saturated at 32767.
// The sphere radius is written through cfg_we / cfg_wdata while no beat
// is in flight; it resets to 6371.
// The datapath is a row of register cells: input decode, angle folding,
// four 32-cell rotation chains for the sines and cosines, the multiply
// and sum stages, two 31-cell square-root chains, a 32-cell vectoring
// chain and a scaling stage. One beat per cycle is taken while the skid
// register is empty; the length of the cell rows sets the latency.
// Reset empties every stage and the output registers.
// When the receiver stalls, results collect in the output register and
// one skid register; once the skid register is full, s_axis_tready falls
// and the whole row holds until the receiver takes a beat.
`include "assert_macros.svh"

module great_circle_distance import gcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // lat_a_deg, lat_a_min, lon_a_deg, lon_a_min,
  // lat_b_deg, lat_b_min, lon_b_deg, lon_b_min, zero fill
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // distance_km, zero fill
  output logic [OUT_W-1:0]    m_axis_tdata,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata
);

  localparam int LANES     = 4;
  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LATA = 2;
  localparam int LANE_LATB = 3;

  function automatic logic signed [UW-1:0] total_min(input logic signed [8:0] deg,
                                                     input logic [5:0] mins);
    return UW'(deg) * MIN_PER_DEG + $signed(UW'(mins));
  endfunction

  // Product truncated toward zero, as sign and magnitude.
  function automatic logic signed [XW-1:0] mul_qf(input logic signed [XW-1:0] a,
                                                  input logic signed [XW-1:0] b);
    logic [XW-1:0]   ma;
    logic [XW-1:0]   mb;
    logic [2*XW-1:0] p;
    logic [XW-1:0]   m;
    ma = a[XW-1] ? XW'(-a) : XW'(a);
    mb = b[XW-1] ? XW'(-b) : XW'(b);
    p  = ma * mb;
    m  = p[FRAC +: XW];
    return (a[XW-1] ^ b[XW-1]) ? -$signed(m) : $signed(m);
  endfunction

  logic en;
  logic [RADIUS_W-1:0] radius;

  // Decode: angles in half-minute units of the half or full angle.
  logic signed [UW-1:0] lat_a, lon_a, lat_b, lon_b;
  logic signed [UW-1:0] units [LANES];
  logic signed [UW-1:0] u0 [LANES];
  logic                 vld0;

  always_comb begin
    lat_a = total_min($signed(s_axis_tdata[7:0]), s_axis_tdata[13:8]);
    lon_a = total_min($signed(s_axis_tdata[22:14]), s_axis_tdata[28:23]);
    lat_b = total_min($signed(s_axis_tdata[36:29]), s_axis_tdata[42:37]);
    lon_b = total_min($signed(s_axis_tdata[51:43]), s_axis_tdata[57:52]);
    units[LANE_DLAT] = lat_b - lat_a;
    units[LANE_DLON] = lon_b - lon_a;
    units[LANE_LATA] = lat_a <<< 1;
    units[LANE_LATB] = lat_b <<< 1;
  end

  // Fold into [-90, 90] degrees; a fold flips the sign of the cosine.
  logic signed [UW-1:0] red [LANES];
  logic                 fold [LANES];
  logic [RW-1:0]        mag1 [LANES];
  logic                 rneg1 [LANES];
  logic                 cneg1 [LANES];
  logic                 vld1;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      red[j]  = u0[j];
      fold[j] = 1'b0;
      if (red[j] >= HALF_TURN) begin
        red[j] = red[j] - FULL_TURN;
      end else if (red[j] < -HALF_TURN) begin
        red[j] = red[j] + FULL_TURN;
      end
      if (red[j] > QUARTER_TURN) begin
        red[j]  = HALF_TURN - red[j];
        fold[j] = 1'b1;
      end else if (red[j] < -QUARTER_TURN) begin
        red[j]  = -HALF_TURN - red[j];
        fold[j] = 1'b1;
      end
    end
  end

  // Radians from the magnitude in half-minute steps.
  logic [63:0]          th_q62 [LANES];
  logic signed [XW-1:0] th_mag [LANES];
  cordic_t              rot [LANES][STEPS+1];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      th_q62[j] = 64'(mag1[j]) * STEP_Q62;
      th_mag[j] = XW'(q62_to_qf(th_q62[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else if (en) begin
      vld0 <= s_axis_tvalid;
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        u0[j]    <= units[j];
        mag1[j]  <= RW'(red[j][UW-1] ? -red[j] : red[j]);
        rneg1[j] <= red[j][UW-1];
        cneg1[j] <= fold[j];
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        rot[j][0].vld <= 1'b0;
      end else if (en) begin
        rot[j][0].vld <= vld1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot[j][0].neg <= cneg1[j];
        rot[j][0].x   <= CORDIC_X0;
        rot[j][0].y   <= '0;
        rot[j][0].z   <= rneg1[j] ? -th_mag[j] : th_mag[j];
      end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
      gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .din  (rot[j][i]),
        .dout (rot[j][i+1])
      );
    end
  end

  // Haversine term a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2).
  logic signed [XW-1:0] cos_a, cos_b;
  logic signed [XW-1:0] p1, p2, p3, p1d, p4;
  logic signed [XW:0]   hsum;
  logic [FRAC:0]        hav;
  logic                 vldm1, vldm2;
  sqrt_t                sq_a [FRAC+2];
  sqrt_t                sq_b [FRAC+2];

  always_comb begin
    cos_a = rot[LANE_LATA][STEPS].neg ? -rot[LANE_LATA][STEPS].x : rot[LANE_LATA][STEPS].x;
    cos_b = rot[LANE_LATB][STEPS].neg ? -rot[LANE_LATB][STEPS].x : rot[LANE_LATB][STEPS].x;
    hsum  = (XW+1)'(p1d) + (XW+1)'(p4);
    if (hsum[XW]) begin
      hav = '0;
    end else if (hsum > (XW+1)'(1) <<< FRAC) begin
      hav = (FRAC+1)'(1) << FRAC;
    end else begin
      hav = hsum[FRAC:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vldm1         <= 1'b0;
      vldm2         <= 1'b0;
      sq_a[0].vld   <= 1'b0;
      sq_b[0].vld   <= 1'b0;
    end else if (en) begin
      vldm1         <= rot[LANE_DLAT][STEPS].vld;
      vldm2         <= vldm1;
      sq_a[0].vld   <= vldm2;
      sq_b[0].vld   <= vldm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1           <= mul_qf(rot[LANE_DLAT][STEPS].y, rot[LANE_DLAT][STEPS].y);
      p2           <= mul_qf(cos_a, cos_b);
      p3           <= mul_qf(rot[LANE_DLON][STEPS].y, rot[LANE_DLON][STEPS].y);
      p1d          <= p1;
      p4           <= mul_qf(p2, p3);
      sq_a[0].rem  <= '0;
      sq_a[0].root <= '0;
      sq_a[0].rad  <= RADW'({hav, {FRAC{1'b0}}});
      sq_b[0].rem  <= '0;
      sq_b[0].root <= '0;
      sq_b[0].rad  <= RADW'({((FRAC+1)'(1) << FRAC) - hav, {FRAC{1'b0}}});
    end
  end

  for (genvar i = 0; i <= FRAC; i++) begin : g_sqrt
    gcd_sqrt_cell u_sqrt_a (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq_a[i]),
      .dout (sq_a[i+1])
    );
    gcd_sqrt_cell u_sqrt_b (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq_b[i]),
      .dout (sq_b[i+1])
    );
  end

  // Central angle c = 2 atan2(sqrt(a), sqrt(1 - a)).
  cordic_t vec [STEPS+1];

  always_comb begin
    vec[0].vld = sq_a[FRAC+1].vld;
    vec[0].neg = 1'b0;
    vec[0].x   = $signed(XW'(sq_b[FRAC+1].root));
    vec[0].y   = $signed(XW'(sq_a[FRAC+1].root));
    vec[0].z   = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (vec[i]),
      .dout (vec[i+1])
    );
  end

  // Scale by the radius and saturate.
  logic signed [XW:0]        ang2;
  logic [XW-1:0]             ang_mag;
  logic [RADIUS_W+XW-1:0]    scaled;
  logic [DIST_W-1:0]         dist_sat;
  logic [DIST_W-1:0]         dist_f;
  logic                      vld_f;

  always_comb begin
    ang2     = $signed({vec[STEPS].z, 1'b0});
    ang_mag  = ang2[XW] ? '0 : ang2[XW-1:0];
    scaled   = (RADIUS_W+XW)'(radius) * (RADIUS_W+XW)'(ang_mag);
    dist_sat = (|scaled[RADIUS_W+XW-1:FRAC+DIST_W]) ? '1 : scaled[FRAC +: DIST_W];
  end

  // Output register plus one skid register.
  logic              out_vld;
  logic [DIST_W-1:0] out_data;
  logic              skid_vld;
  logic [DIST_W-1:0] skid_data;

  assign en            = ~skid_vld;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = OUT_W'(out_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RESET;
      vld_f    <= 1'b0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      if (en) begin
        vld_f <= vec[STEPS].vld;
      end
      if (skid_vld) begin
        if (m_axis_tready) begin
          skid_vld <= 1'b0;
        end
      end else if (vld_f) begin
        if (!out_vld || m_axis_tready) begin
          out_vld <= 1'b1;
        end else begin
          skid_vld <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_f <= dist_sat;
    end
    if (skid_vld) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
      end
    end else if (vld_f) begin
      if (!out_vld || m_axis_tready) begin
        out_data <= dist_f;
      end else begin
        skid_data <= dist_f;
      end
    end
  end

  `ASSERT_IMP(a_skid_behind_out, clk, rst, skid_vld, m_axis_tvalid)
  `ASSERT_NEXT(a_skid_fill, clk, rst, vld_f && !skid_vld && m_axis_tvalid && !m_axis_tready, skid_vld)
  `ASSERT_NEXT(a_stall_holds, clk, rst, skid_vld && !m_axis_tready, skid_vld && $stable(vld_f))

endmodule

/* dv/great_circle_distance_tb.sv */
// Self-checking testbench for the great_circle_distance block: streams position pairs
// through it and checks each distance against a fixed-point haversine predictor.
// Depends on gcd_pkg and the great_circle_distance RTL.
module great_circle_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int QF = 30;
  localparam int ROT_STEPS = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 150;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_we;
  logic [RADIUS_W-1:0] cfg_wdata;

  great_circle_distance uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [63:0]      pair_queue[$];
  logic [14:0]      expected_km[$];
  longint           arctan_lut[ROT_STEPS];
  logic [63:0]      half_min_step;
  logic [12:0]      radius_km;
  logic             fired;
  int               burst_left;
  int               gap_left;
  int               cycle_count;
  int               mismatches;
  int               checked;
  int               sent_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] round_to_qf(input logic [63:0] v);
    return (v + (64'd1 << 31)) >> 32;
  endfunction

  function automatic void build_arctan_lut();
    longint acc;
    longint term;
    int e;
    half_min_step = (64'h3243F6A8885A308D * 64'd4) / 64'd21600;
    for (int i = 0; i < ROT_STEPS; i++) begin
      acc = 64'h3243F6A8885A308D;
      if (i > 0) begin
        acc = 0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = longint'((64'd1 << (62 - e)) / 64'(2 * k + 1));
            acc = k[0] ? acc - term : acc + term;
          end
        end
      end
      arctan_lut[i] = longint'(round_to_qf(acc));
    end
  endfunction

  function automatic longint qf_mul(input longint a, input longint b);
    logic [127:0] prod;
    logic [63:0]  mag;
    prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    mag = prod[QF +: 64];
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  // Sine and cosine of an angle in half-minute units, folded into +-90 degrees.
  function automatic void rotate_angle(input longint units, output longint sn,
                                       output longint cs);
    longint r, th, x, y, z, xs, ys;
    bit flip;
    r = ((units % 43200) + 43200) % 43200;
    flip = 1'b0;
    if (r >= 21600) r -= 43200;
    if (r > 10800) begin
      r = 21600 - r;
      flip = 1'b1;
    end else if (r < -10800) begin
      r = -21600 - r;
      flip = 1'b1;
    end
    th = longint'(round_to_qf(64'(r < 0 ? -r : r) * half_min_step));
    if (r < 0) th = -th;
    x = longint'(round_to_qf(64'd2800459870029452305));
    y = 0;
    z = th;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_lut[i];
      end else begin
        x += ys; y -= xs; z += arctan_lut[i];
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint floor_root(input longint a);
    logic [127:0] target;
    logic [63:0]  r, cand;
    target = 128'(a) << QF;
    r = 0;
    for (int b = QF; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= target) r = cand;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan_lut[i];
      end else begin
        x -= ys; y += xs; z -= arctan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic logic [14:0] haversine_km(input logic [63:0] w, input logic [12:0] rad);
    longint lat_a, lon_a, lat_b, lon_b;
    longint s_lat, s_lon, c_a, c_b, unused, a, one, c;
    logic [63:0] d;
    lat_a = longint'($signed(w[7:0])) * 60 + longint'(w[13:8]);
    lon_a = longint'($signed(w[22:14])) * 60 + longint'(w[28:23]);
    lat_b = longint'($signed(w[36:29])) * 60 + longint'(w[42:37]);
    lon_b = longint'($signed(w[51:43])) * 60 + longint'(w[57:52]);
    // A difference in minutes is the half angle in half-minute units.
    rotate_angle(lat_b - lat_a, s_lat, unused);
    rotate_angle(lon_b - lon_a, s_lon, unused);
    rotate_angle(lat_a * 2, unused, c_a);
    rotate_angle(lat_b * 2, unused, c_b);
    a = qf_mul(s_lat, s_lat) + qf_mul(qf_mul(c_a, c_b), qf_mul(s_lon, s_lon));
    one = longint'(1) << QF;
    if (a < 0) a = 0;
    if (a > one) a = one;
    c = 2 * vector_angle(floor_root(a), floor_root(one - a));
    if (c < 0) c = 0;
    d = (64'(rad) * 64'(c)) >> QF;
    if (d > 64'h7FFF) d = 64'h7FFF;
    return d[14:0];
  endfunction

  function automatic logic [63:0] pack_pair(input int la, input int lam, input int lo,
                                            input int lom, input int lb, input int lbm,
                                            input int lo2, input int lo2m);
    return {6'd0, 6'(lo2m), 9'(lo2), 6'(lbm), 8'(lb), 6'(lom), 9'(lo), 6'(lam), 8'(la)};
  endfunction

  function automatic logic [63:0] random_pair();
    int la, lo, sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return {6'd0, 58'({$urandom, $urandom})};
    la = $urandom_range(0, 180) - 90;
    lo = $urandom_range(0, 360) - 180;
    if (sel < 20) // nearly the same point
      return pack_pair(la, $urandom_range(0, 59), lo, $urandom_range(0, 59),
                       la, $urandom_range(0, 59), lo, $urandom_range(0, 59));
    if (sel < 28) // nearly antipodal
      return pack_pair(la, 0, lo, 0, -la, $urandom_range(0, 2), lo + (lo > 0 ? -180 : 180),
                       $urandom_range(0, 2));
    return pack_pair(la, $urandom_range(0, 59), lo, $urandom_range(0, 59),
                     $urandom_range(0, 180) - 90, $urandom_range(0, 59),
                     $urandom_range(0, 360) - 180, $urandom_range(0, 59));
  endfunction

  // Sender: bursts of beats with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || fired) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        s_axis_tdata  <= pair_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: the stall density changes with bits 9:8 of the cycle count.
  always @(negedge clk) begin
    case (cycle_count[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    fired <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_km.push_back(haversine_km(s_axis_tdata, radius_km));
      sent_count <= sent_count + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked <= checked + 1;
      if (expected_km.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat %0d", m_axis_tdata);
      end else if (m_axis_tdata !== {1'b0, expected_km[0]}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance mismatch: expected %0d got %0d", expected_km[0], m_axis_tdata);
        void'(expected_km.pop_front());
      end else begin
        void'(expected_km.pop_front());
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("great_circle_distance test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pair_queue.size() > 0 || s_axis_tvalid || expected_km.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_radius(input logic [12:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    radius_km = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [12:0] radii[5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    m_axis_tready = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    checked = 0;
    sent_count = 0;
    burst_left = 1;
    gap_left = 0;
    fired = 1'b0;
    radius_km = 13'd6371;
    build_arctan_lut();
    radii = '{13'd6371, 13'd8191, 13'd1, 13'd0, 13'($urandom_range(2, 8190))};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pairs under the reset radius.
    pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pair_queue.push_back(pack_pair(90, 0, 0, 0, -90, 0, 0, 0));
    pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 180, 0));
    pair_queue.push_back(pack_pair(0, 0, -180, 0, 0, 0, 180, 0));
    pair_queue.push_back(pack_pair(0, 0, -180, 0, 0, 0, 0, 0));
    pair_queue.push_back(pack_pair(89, 59, 179, 59, -90, 0, -180, 0));
    pair_queue.push_back(pack_pair(-10, 30, 20, 59, -9, 30, 20, 0));
    pair_queue.push_back(pack_pair(45, 0, 10, 0, 45, 1, 10, 0));
    pair_queue.push_back(pack_pair(45, 0, 10, 0, 45, 0, 10, 1));
    pair_queue.push_back(pack_pair(-128, 63, -256, 63, 127, 63, 255, 63));
    pair_queue.push_back(pack_pair(127, 0, 255, 0, -128, 0, -256, 0));
    pair_queue.push_back(pack_pair(-90, 0, 0, 0, 90, 0, 0, 0));
    pair_queue.push_back(pack_pair(51, 30, 0, 7, 40, 42, -74, 0));
    pair_queue.push_back(pack_pair(-33, 52, 151, 12, 35, 41, 139, 41));
    pair_queue.push_back(pack_pair(0, 0, 179, 59, 0, 0, -179, 59));
    pair_queue.push_back(pack_pair(-1, 59, -1, 59, 1, 59, 1, 59));

    foreach (radii[p]) begin
      write_radius(radii[p]);
      for (int n = 0; n < 165; n++) pair_queue.push_back(random_pair());
      // Let the pipeline drain completely halfway through the phase.
      wait_drained();
      for (int n = 0; n < 165; n++) pair_queue.push_back(random_pair());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d position pairs over five radius settings (0, 1, 6371, 8191, one random);",
             sent_count);
    $display("checked %0d distances, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && expected_km.size() == 0) begin
      $display("great_circle_distance test passed");
    end else begin
      $display("great_circle_distance test failed");
    end
    $finish;
  end
endmodule
